// ----- rtl/dmts_pkg.sv -----
// ----------------------------------------------------------------------------
// dmts_pkg
// shared types, codes and the task ordering rule of the scheduler
// ----------------------------------------------------------------------------
package dmts_pkg;

   localparam int IDENT_W    = 16;
   localparam int TIME_W     = 31;
   localparam int LEVEL_W    = 4;
   localparam int SLACK_W    = 42;
   localparam int WEIGHT_W   = 10;
   localparam int FRAC_W     = 16;
   localparam int GAP_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_ARRIVE  = 3'd1,
      OP_FINISH  = 3'd2,
      OP_TO_IO   = 3'd3,
      OP_IO_DONE = 3'd4,
      OP_DECIDE  = 3'd5
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_HIGH  = 2'd0,
      CSR_WEIGHT_LOW   = 2'd1,
      CSR_GAP_FRACTION = 2'd2
   } csr_type;

   // one row of the task table
   typedef struct packed {
      logic [IDENT_W-1:0]       ident;
      logic [TIME_W-1:0]        deadline;
      logic [LEVEL_W-1:0]       level;
      logic signed [SLACK_W-1:0] slack;
   } task_entry_type;

   // requests to the gap unit
   typedef struct packed {
      logic                    look;
      logic                    ins;
      logic [FRAC_W-1:0]       frac;
      logic signed [GAP_W-1:0] gval;
   } gap_cmd_type;

   typedef struct packed {
      logic                    done;
      logic signed [GAP_W-1:0] pg;
   } gap_rsp_type;

   // higher level first, then smaller slack, then earlier deadline
   function automatic logic goes_before(task_entry_type a, task_entry_type b);
      logic r;
      if (a.level != b.level) begin
         r = a.level > b.level;
      end else if (a.slack != b.slack) begin
         r = a.slack < b.slack;
      end else begin
         r = a.deadline < b.deadline;
      end
      return r;
   endfunction

endpackage

// ----- rtl/dmts_if.sv -----
// ----------------------------------------------------------------------------
// dmts channel interfaces
// valid/ready channels for event words and decision words
// ----------------------------------------------------------------------------
interface dmts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [30:0] event_time;
   logic [15:0] task_ident;
   logic [30:0] arrival_time;
   logic [30:0] due_time;
   logic        high_priority;
   logic [15:0] running_cpu;
   logic [15:0] running_io;

   modport source (output valid, opcode, event_time, task_ident, arrival_time,
                   due_time, high_priority, running_cpu, running_io,
                   input ready);
   modport sink   (input valid, opcode, event_time, task_ident, arrival_time,
                   due_time, high_priority, running_cpu, running_io,
                   output ready);
endinterface

interface dmts_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] cpu_choice;
   logic [15:0] io_choice;

   modport source (output valid, cpu_choice, io_choice, input ready);
   modport sink   (input valid, cpu_choice, io_choice, output ready);
endinterface

// ----- rtl/dmts_gap_unit.sv -----
// ----------------------------------------------------------------------------
// dmts_gap_unit
// sorted store of distinct i/o start gaps with percentile lookup and insert
// ----------------------------------------------------------------------------
module dmts_gap_unit #(
   parameter int GAPS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dmts_pkg::gap_cmd_type cmd,
   output dmts_pkg::gap_rsp_type rsp
);

   localparam int CW = $clog2(GAPS + 1);
   localparam int GW = (GAPS > 1) ? $clog2(GAPS) : 1;

   typedef enum logic [2:0] {
      G_IDLE, G_LOOK, G_FIND, G_FCMP, G_PLACE, G_SHIFT, G_SWR
   } gstate_type;

   gstate_type gst_ff, gst_in;
   logic [CW-1:0] cnt_ff, cnt_in, pos_ff, pos_in, k_ff, k_in;
   logic signed [dmts_pkg::GAP_W-1:0] g_ff, g_in, pg_ff, pg_in;
   logic done_ff, done_in;

   logic signed [dmts_pkg::GAP_W-1:0] mem [GAPS];
   logic signed [dmts_pkg::GAP_W-1:0] rd_q;
   logic [GW-1:0] rd_addr, wr_addr;
   logic wr_en;
   logic signed [dmts_pkg::GAP_W-1:0] wr_data;

   logic [CW+dmts_pkg::FRAC_W-1:0] lk_prod;
   logic [CW-1:0] lk_idx, k_dec;

   always_comb begin
      lk_prod = CW'(cnt_ff) * (CW + dmts_pkg::FRAC_W)'(cmd.frac);
      lk_idx  = lk_prod[CW+dmts_pkg::FRAC_W-1:dmts_pkg::FRAC_W];
      if (lk_idx >= cnt_ff && cnt_ff != '0) begin
         lk_idx = cnt_ff - CW'(1);
      end
      k_dec = k_ff - CW'(1);
   end

   always_comb begin
      gst_in  = gst_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      pg_in   = pg_ff;
      done_in = 1'b0;
      rd_addr = pos_ff[GW-1:0];
      wr_en   = 1'b0;
      wr_addr = pos_ff[GW-1:0];
      wr_data = g_ff;
      case (gst_ff)
         G_IDLE: begin
            if (cmd.look) begin
               rd_addr = lk_idx[GW-1:0];
               gst_in  = G_LOOK;
            end else if (cmd.ins) begin
               g_in   = cmd.gval;
               pos_in = '0;
               gst_in = G_FIND;
            end
         end
         G_LOOK: begin
            // empty store reads as a zero gap
            pg_in   = (cnt_ff == '0) ? '0 : rd_q;
            done_in = 1'b1;
            gst_in  = G_IDLE;
         end
         G_FIND: begin
            if (pos_ff == cnt_ff) begin
               gst_in = G_PLACE;
            end else begin
               rd_addr = pos_ff[GW-1:0];
               gst_in  = G_FCMP;
            end
         end
         G_FCMP: begin
            if (rd_q < g_ff) begin
               pos_in = pos_ff + CW'(1);
               gst_in = G_FIND;
            end else if (rd_q == g_ff) begin
               done_in = 1'b1;
               gst_in  = G_IDLE;
            end else begin
               gst_in = G_PLACE;
            end
         end
         G_PLACE: begin
            if (cnt_ff >= CW'(GAPS)) begin
               done_in = 1'b1;
               gst_in  = G_IDLE;
            end else begin
               k_in   = cnt_ff;
               gst_in = G_SHIFT;
            end
         end
         G_SHIFT: begin
            if (k_ff > pos_ff) begin
               rd_addr = k_dec[GW-1:0];
               gst_in  = G_SWR;
            end else begin
               wr_en   = 1'b1;
               cnt_in  = cnt_ff + CW'(1);
               done_in = 1'b1;
               gst_in  = G_IDLE;
            end
         end
         G_SWR: begin
            wr_en   = 1'b1;
            wr_addr = k_ff[GW-1:0];
            wr_data = rd_q;
            k_in    = k_dec;
            gst_in  = G_SHIFT;
         end
         default: gst_in = G_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gst_ff  <= G_IDLE;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         gst_ff  <= gst_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      pos_ff <= pos_in;
      k_ff   <= k_in;
      g_ff   <= g_in;
      pg_ff  <= pg_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q <= mem[rd_addr];
   end

   assign rsp.done = done_ff;
   assign rsp.pg   = pg_ff;

endmodule

// ----- rtl/deadline_mlfq_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// deadline_mlfq_task_scheduler
// deadline-aware multilevel feedback queue scheduler, task table in memory
// ----------------------------------------------------------------------------
//  channel  | dir | word                          | accepted when
//  req_chan | in  | opcode, times, ident, running | valid && ready
//  rsp_chan | out | cpu_choice, io_choice         | valid && ready
//  csr_*    | in  | index, data                   | csr_write high
//
//  tick latches the time and marks a tick; arrival searches for the lowest free slot
//  finish, to-io, io-done take one table walk each
//  decide takes one to three table walks (cpu, optional io, optional
//  demotion); with i/o idle it adds the gap lookup and, with a task waiting,
//  a sorted insert into the gap store; walks and inserts go one row at a
//  time through the single read port of each memory
//  reset is synchronous; both memories need no clearing pass
//  a finished decision waits in the output register; events are still taken
// ----------------------------------------------------------------------------
module deadline_mlfq_task_scheduler #(
   parameter int TASKS     = 32,
   parameter int GAPS      = 64,
   parameter int TOP_LEVEL = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   dmts_req_if.sink                           req_chan,
   dmts_rsp_if.source                         rsp_chan,
   input  logic                               csr_write,
   input  logic [dmts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dmts_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int IW = $clog2(TASKS);
   localparam int NW = $clog2(TASKS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_FREE, S_SCAN, S_GLOOK, S_GINS, S_OUT
   } state_type;

   // what a table walk is for
   typedef enum logic [2:0] {
      J_FIN, J_TOIO, J_IODONE, J_IO, J_CPU, J_DEM
   } job_type;

   state_type state_ff, state_in;
   job_type   job_ff, job_in;

   // configuration
   logic [dmts_pkg::WEIGHT_W-1:0] wh_ff, wh_in, wl_ff, wl_in;
   logic [dmts_pkg::FRAC_W-1:0]   gf_ff, gf_in;

   // per-slot flags
   logic [TASKS-1:0] valid_ff, valid_in, inio_ff, inio_in;

   // scalar scheduler state
   logic signed [31:0] ct_ff, ct_in, lis_ff, lis_in;
   logic [dmts_pkg::IDENT_W-1:0] prev_ff, prev_in;
   logic tick_ff, tick_in;

   // latched event word
   logic [dmts_pkg::IDENT_W-1:0] sid_ff, sid_in, rcpu_ff, rcpu_in;
   logic [dmts_pkg::TIME_W-1:0]  due_ff, due_in;
   logic signed [dmts_pkg::SLACK_W-1:0] prod_ff, prod_in;

   // table walk
   logic [NW-1:0] issue_ff, issue_in, fr_ff, fr_in;
   logic          rv_ff, rv_in;
   logic [IW-1:0] ri_ff, ri_in;
   logic          side_ff, side_in, kind_ff, kind_in;
   logic signed [31:0] thr_ff, thr_in;
   logic anyf_ff, anyf_in, filtf_ff, filtf_in;
   dmts_pkg::task_entry_type any_e_ff, any_e_in, filt_e_ff, filt_e_in;
   logic [IW-1:0] filt_i_ff, filt_i_in;

   // decision
   logic [dmts_pkg::IDENT_W-1:0] io_out_ff, io_out_in, cpu_out_ff, cpu_out_in;
   logic chead_ff, chead_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [dmts_pkg::IDENT_W-1:0] rsp_cpu_ff, rsp_cpu_in, rsp_io_ff, rsp_io_in;

   dmts_pkg::gap_cmd_type gcmd_ff, gcmd_in;
   dmts_pkg::gap_rsp_type grsp;

   // task table memory
   dmts_pkg::task_entry_type tmem [TASKS];
   dmts_pkg::task_entry_type rd_q, wr_data;
   logic [IW-1:0] rd_addr, wr_addr;
   logic wr_en;

   // datapath helpers
   logic signed [31:0] diff;
   logic signed [dmts_pkg::SLACK_W:0] prod_full;
   logic [dmts_pkg::WEIGHT_W-1:0] wsel;
   logic signed [33:0] dl_lhs, dl_rhs;
   logic dl_ok, elig, match, scan_done, fin;
   logic signed [32:0] gap_raw;
   logic signed [31:0] gap_sat;

   dmts_gap_unit #(.GAPS(GAPS)) u_gap (
      .clock (clock),
      .reset (reset),
      .cmd   (gcmd_ff),
      .rsp   (grsp)
   );

   always_comb begin
      // weighted slack of an arriving task
      diff      = $signed({1'b0, req_chan.due_time}) - $signed({1'b0, req_chan.arrival_time});
      wsel      = req_chan.high_priority ? wh_ff : wl_ff;
      prod_full = (dmts_pkg::SLACK_W + 1)'(diff * $signed({1'b0, wsel}));
      // deadline minus threshold against the current time
      dl_lhs    = $signed({3'b000, rd_q.deadline}) - 34'(thr_ff);
      dl_rhs    = 34'(ct_ff);
      dl_ok     = dl_lhs > dl_rhs;
      elig      = rv_ff && valid_ff[ri_ff] && (inio_ff[ri_ff] == side_ff);
      match     = kind_ff ? dl_ok : (rd_q.ident == sid_ff);
      scan_done = (issue_ff == NW'(TASKS)) && !rv_ff;
      // io start gap, saturated to 32 bits
      gap_raw   = 33'(ct_ff) - 33'(lis_ff);
      if (gap_raw[32] != gap_raw[31]) begin
         gap_sat = gap_raw[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         gap_sat = gap_raw[31:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      wh_in        = wh_ff;
      wl_in        = wl_ff;
      gf_in        = gf_ff;
      valid_in     = valid_ff;
      inio_in      = inio_ff;
      ct_in        = ct_ff;
      lis_in       = lis_ff;
      prev_in      = prev_ff;
      tick_in      = tick_ff;
      sid_in       = sid_ff;
      rcpu_in      = rcpu_ff;
      due_in       = due_ff;
      prod_in      = prod_ff;
      issue_in     = issue_ff;
      fr_in        = fr_ff;
      rv_in        = 1'b0;
      ri_in        = ri_ff;
      side_in      = side_ff;
      kind_in      = kind_ff;
      thr_in       = thr_ff;
      anyf_in      = anyf_ff;
      filtf_in     = filtf_ff;
      any_e_in     = any_e_ff;
      filt_e_in    = filt_e_ff;
      filt_i_in    = filt_i_ff;
      io_out_in    = io_out_ff;
      cpu_out_in   = cpu_out_ff;
      chead_in     = chead_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_cpu_in   = rsp_cpu_ff;
      rsp_io_in    = rsp_io_ff;
      gcmd_in      = '0;
      gcmd_in.frac = gf_ff;
      rd_addr      = issue_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = filt_i_ff;
      wr_data      = filt_e_ff;
      fin          = 1'b0;

      if (csr_write) begin
         case (csr_index)
            dmts_pkg::CSR_WEIGHT_HIGH:  wh_in = csr_data[dmts_pkg::WEIGHT_W-1:0];
            dmts_pkg::CSR_WEIGHT_LOW:   wl_in = csr_data[dmts_pkg::WEIGHT_W-1:0];
            dmts_pkg::CSR_GAP_FRACTION: gf_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               sid_in   = req_chan.task_ident;
               issue_in = '0;
               anyf_in  = 1'b0;
               filtf_in = 1'b0;
               kind_in  = 1'b0;
               side_in  = 1'b0;
               case (dmts_pkg::op_type'(req_chan.opcode))
                  dmts_pkg::OP_TICK: begin
                     ct_in   = $signed({1'b0, req_chan.event_time});
                     tick_in = 1'b1;
                  end
                  dmts_pkg::OP_ARRIVE: begin
                     prod_in  = prod_full[dmts_pkg::SLACK_W-1:0];
                     due_in   = req_chan.due_time;
                     fr_in    = '0;
                     state_in = S_FREE;
                  end
                  dmts_pkg::OP_FINISH: begin
                     job_in   = J_FIN;
                     state_in = S_SCAN;
                  end
                  dmts_pkg::OP_TO_IO: begin
                     job_in   = J_TOIO;
                     state_in = S_SCAN;
                  end
                  dmts_pkg::OP_IO_DONE: begin
                     side_in  = 1'b1;
                     job_in   = J_IODONE;
                     state_in = S_SCAN;
                  end
                  dmts_pkg::OP_DECIDE: begin
                     rcpu_in    = req_chan.running_cpu;
                     io_out_in  = req_chan.running_io;
                     cpu_out_in = req_chan.running_cpu;
                     chead_in   = 1'b0;
                     if (req_chan.running_io == '0) begin
                        gcmd_in.look = 1'b1;
                        state_in     = S_GLOOK;
                     end else begin
                        kind_in  = 1'b1;
                        thr_in   = '0;
                        job_in   = J_CPU;
                        state_in = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_FREE: begin
            // lowest free slot takes the arrival; full table drops it
            if (fr_ff == NW'(TASKS)) begin
               state_in = S_IDLE;
            end else if (!valid_ff[fr_ff[IW-1:0]]) begin
               wr_en            = 1'b1;
               wr_addr          = fr_ff[IW-1:0];
               wr_data.ident    = sid_ff;
               wr_data.deadline = due_ff;
               wr_data.level    = dmts_pkg::LEVEL_W'(TOP_LEVEL);
               wr_data.slack    = prod_ff;
               valid_in[fr_ff[IW-1:0]] = 1'b1;
               inio_in[fr_ff[IW-1:0]]  = 1'b0;
               state_in         = S_IDLE;
            end else begin
               fr_in = fr_ff + NW'(1);
            end
         end

         S_GLOOK: begin
            if (grsp.done) begin
               thr_in   = grsp.pg;
               side_in  = 1'b1;
               kind_in  = 1'b1;
               issue_in = '0;
               anyf_in  = 1'b0;
               filtf_in = 1'b0;
               job_in   = J_IO;
               state_in = S_SCAN;
            end
         end

         S_GINS: begin
            if (grsp.done) begin
               side_in  = 1'b0;
               kind_in  = 1'b1;
               thr_in   = '0;
               issue_in = '0;
               anyf_in  = 1'b0;
               filtf_in = 1'b0;
               job_in   = J_CPU;
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            // issue one read a cycle, judge the row read the cycle before
            if (issue_ff != NW'(TASKS)) begin
               rv_in    = 1'b1;
               ri_in    = issue_ff[IW-1:0];
               issue_in = issue_ff + NW'(1);
            end
            if (elig && (!anyf_ff || dmts_pkg::goes_before(rd_q, any_e_ff))) begin
               anyf_in  = 1'b1;
               any_e_in = rd_q;
            end
            if (elig && match && (!filtf_ff || dmts_pkg::goes_before(rd_q, filt_e_ff))) begin
               filtf_in  = 1'b1;
               filt_e_in = rd_q;
               filt_i_in = ri_ff;
            end
            if (scan_done) begin
               case (job_ff)
                  J_FIN: begin
                     if (filtf_ff) valid_in[filt_i_ff] = 1'b0;
                     state_in = S_IDLE;
                  end
                  J_TOIO: begin
                     if (filtf_ff) inio_in[filt_i_ff] = 1'b1;
                     state_in = S_IDLE;
                  end
                  J_IODONE: begin
                     if (filtf_ff) inio_in[filt_i_ff] = 1'b0;
                     state_in = S_IDLE;
                  end
                  J_IO: begin
                     if (anyf_ff) begin
                        io_out_in    = filtf_ff ? filt_e_ff.ident : any_e_ff.ident;
                        gcmd_in.ins  = 1'b1;
                        gcmd_in.gval = gap_sat;
                        lis_in       = ct_ff;
                        state_in     = S_GINS;
                     end else begin
                        side_in  = 1'b0;
                        kind_in  = 1'b1;
                        thr_in   = '0;
                        issue_in = '0;
                        anyf_in  = 1'b0;
                        filtf_in = 1'b0;
                        job_in   = J_CPU;
                     end
                  end
                  J_CPU: begin
                     chead_in = anyf_ff;
                     if (anyf_ff) begin
                        cpu_out_in = filtf_ff ? filt_e_ff.ident : any_e_ff.ident;
                     end
                     // demote the task that ran again since the last tick
                     if (tick_ff && prev_ff != '0 && prev_ff == rcpu_ff) begin
                        side_in  = 1'b0;
                        kind_in  = 1'b0;
                        sid_in   = rcpu_ff;
                        issue_in = '0;
                        anyf_in  = 1'b0;
                        filtf_in = 1'b0;
                        job_in   = J_DEM;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  J_DEM: begin
                     if (filtf_ff && filt_e_ff.level != '0) begin
                        wr_en         = 1'b1;
                        wr_data.level = filt_e_ff.level - dmts_pkg::LEVEL_W'(1);
                     end
                     fin = 1'b1;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_cpu_in   = cpu_out_ff;
               rsp_io_in    = io_out_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // close out a decide
      if (fin) begin
         if (tick_ff && chead_in) prev_in = cpu_out_in;
         tick_in  = 1'b0;
         state_in = S_OUT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= J_FIN;
         wh_ff        <= dmts_pkg::WEIGHT_W'(422);
         wl_ff        <= dmts_pkg::WEIGHT_W'(367);
         gf_ff        <= dmts_pkg::FRAC_W'(655);
         valid_ff     <= '0;
         inio_ff      <= '0;
         ct_ff        <= -32'sd1;
         lis_ff       <= '0;
         prev_ff      <= '0;
         tick_ff      <= 1'b0;
         issue_ff     <= '0;
         rv_ff        <= 1'b0;
         anyf_ff      <= 1'b0;
         filtf_ff     <= 1'b0;
         chead_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gcmd_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         wh_ff        <= wh_in;
         wl_ff        <= wl_in;
         gf_ff        <= gf_in;
         valid_ff     <= valid_in;
         inio_ff      <= inio_in;
         ct_ff        <= ct_in;
         lis_ff       <= lis_in;
         prev_ff      <= prev_in;
         tick_ff      <= tick_in;
         issue_ff     <= issue_in;
         rv_ff        <= rv_in;
         anyf_ff      <= anyf_in;
         filtf_ff     <= filtf_in;
         chead_ff     <= chead_in;
         rsp_valid_ff <= rsp_valid_in;
         gcmd_ff      <= gcmd_in;
      end
      sid_ff     <= sid_in;
      rcpu_ff    <= rcpu_in;
      due_ff     <= due_in;
      prod_ff    <= prod_in;
      fr_ff      <= fr_in;
      ri_ff      <= ri_in;
      side_ff    <= side_in;
      kind_ff    <= kind_in;
      thr_ff     <= thr_in;
      any_e_ff   <= any_e_in;
      filt_e_ff  <= filt_e_in;
      filt_i_ff  <= filt_i_in;
      io_out_ff  <= io_out_in;
      cpu_out_ff <= cpu_out_in;
      rsp_cpu_ff <= rsp_cpu_in;
      rsp_io_ff  <= rsp_io_in;
   end

   // task table: one write, one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tmem[wr_addr] <= wr_data;
      end
      rd_q <= tmem[rd_addr];
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cpu_choice = rsp_cpu_ff;
   assign rsp_chan.io_choice  = rsp_io_ff;

endmodule

// ----- dv/dmts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmts_checker
// watches the event and decision channels and the register port, keeps its
// own copy of the task table and gap store, predicts each decision word and
// compares it field by field against what the scheduler sends
// ----------------------------------------------------------------------------
module dmts_checker
   import dmts_pkg::*;
#(
   parameter int TASKS     = 32,
   parameter int GAPS      = 64,
   parameter int TOP_LEVEL = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   dmts_req_if                   req,
   dmts_rsp_if                   rsp,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    failures,
   output int                    pending
);

   typedef struct {
      logic [IDENT_W-1:0] cpu;
      logic [IDENT_W-1:0] io;
   } decision_type;

   decision_type decisions_due[$];

   logic [WEIGHT_W-1:0] w_high, w_low;
   logic [FRAC_W-1:0]   frac;

   bit                 valid_q [TASKS];
   bit                 in_io_q [TASKS];
   logic [IDENT_W-1:0] ident_q [TASKS];
   longint             dline_q [TASKS];
   int                 level_q [TASKS];
   longint             slack_q [TASKS];
   longint             gaps    [GAPS];
   int                 gap_cnt;
   longint             now_t;
   longint             io_start_t;
   logic [IDENT_W-1:0] prev_cpu;
   bit                 ticked;

   function automatic bit ahead_of(int a, int b);
      if (level_q[a] != level_q[b]) return level_q[a] > level_q[b];
      if (slack_q[a] != slack_q[b]) return slack_q[a] < slack_q[b];
      if (dline_q[a] != dline_q[b]) return dline_q[a] < dline_q[b];
      return a < b;
   endfunction

   // best slot on one side; optional ident match or deadline-minus-offset test
   function automatic int pick_slot(bit io_side, bit by_ident, logic [IDENT_W-1:0] id,
                                    bit by_time, longint offset);
      int best;
      best = -1;
      for (int i = 0; i < TASKS; i++) begin
         if (!valid_q[i] || in_io_q[i] != io_side) continue;
         if (by_ident && ident_q[i] != id) continue;
         if (by_time && !(dline_q[i] - offset > now_t)) continue;
         if (best < 0 || ahead_of(i, best)) best = i;
      end
      return best;
   endfunction

   function automatic void store_gap(longint g);
      int pos;
      pos = 0;
      while (pos < gap_cnt && gaps[pos] < g) pos++;
      if (pos < gap_cnt && gaps[pos] == g) return;
      if (gap_cnt >= GAPS) return;
      for (int k = gap_cnt; k > pos; k--) gaps[k] = gaps[k-1];
      gaps[pos] = g;
      gap_cnt++;
   endfunction

   task automatic predict_word();
      op_type             op;
      int                 s, head, chead, idx;
      longint             pg, g;
      decision_type       d;
      op = op_type'(req.opcode);
      case (op)
         OP_TICK: begin
            now_t  = longint'(req.event_time);
            ticked = 1;
         end
         OP_ARRIVE: begin
            for (int i = 0; i < TASKS; i++) begin
               if (!valid_q[i]) begin
                  valid_q[i] = 1;
                  in_io_q[i] = 0;
                  ident_q[i] = req.task_ident;
                  dline_q[i] = longint'(req.due_time);
                  level_q[i] = TOP_LEVEL;
                  slack_q[i] = (longint'(req.due_time) - longint'(req.arrival_time)) *
                               longint'(req.high_priority ? w_high : w_low);
                  break;
               end
            end
         end
         OP_FINISH: begin
            s = pick_slot(0, 1, req.task_ident, 0, 0);
            if (s >= 0) valid_q[s] = 0;
         end
         OP_TO_IO: begin
            s = pick_slot(0, 1, req.task_ident, 0, 0);
            if (s >= 0) in_io_q[s] = 1;
         end
         OP_IO_DONE: begin
            s = pick_slot(1, 1, req.task_ident, 0, 0);
            if (s >= 0) in_io_q[s] = 0;
         end
         OP_DECIDE: begin
            d.cpu = req.running_cpu;
            d.io  = req.running_io;
            if (req.running_io == '0) begin
               head = pick_slot(1, 0, '0, 0, 0);
               if (head >= 0) begin
                  pg = 0;
                  if (gap_cnt > 0) begin
                     idx = int'((longint'(gap_cnt) * longint'(frac)) >>> 16);
                     if (idx >= gap_cnt) idx = gap_cnt - 1;
                     pg = gaps[idx];
                  end
                  s = pick_slot(1, 0, '0, 1, pg);
                  if (s < 0) s = head;
                  d.io = ident_q[s];
                  g = now_t - io_start_t;
                  if (g > 64'sd2147483647) g = 64'sd2147483647;
                  if (g < -64'sd2147483648) g = -64'sd2147483648;
                  store_gap(g);
                  io_start_t = now_t;
               end
            end
            chead = pick_slot(0, 0, '0, 0, 0);
            if (chead >= 0) begin
               s = pick_slot(0, 0, '0, 1, 0);
               if (s < 0) s = chead;
               d.cpu = ident_q[s];
            end
            // the task that kept the cpu across a tick drops one level
            if (ticked && prev_cpu != '0 && prev_cpu == req.running_cpu) begin
               s = pick_slot(0, 1, req.running_cpu, 0, 0);
               if (s >= 0 && level_q[s] > 0) level_q[s]--;
            end
            if (ticked && chead >= 0) prev_cpu = d.cpu;
            ticked = 0;
            decisions_due.push_back(d);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      decision_type d;
      if (reset) begin
         w_high = 10'd422;
         w_low  = 10'd367;
         frac   = 16'd655;
         for (int i = 0; i < TASKS; i++) begin
            valid_q[i] = 0;
            in_io_q[i] = 0;
         end
         gap_cnt    = 0;
         now_t      = -1;
         io_start_t = 0;
         prev_cpu   = '0;
         ticked     = 0;
         decisions_due.delete();
      end else begin
         if (csr_write) begin
            case (csr_type'(csr_index))
               CSR_WEIGHT_HIGH:  w_high = csr_data[WEIGHT_W-1:0];
               CSR_WEIGHT_LOW:   w_low  = csr_data[WEIGHT_W-1:0];
               CSR_GAP_FRACTION: frac   = csr_data;
               default: ;
            endcase
         end
         if (req.valid && req.ready) predict_word();
         if (rsp.valid && rsp.ready) begin
            if (decisions_due.size() == 0) begin
               $error("decision word with none expected: cpu %0d io %0d",
                      rsp.cpu_choice, rsp.io_choice);
               failures++;
            end else begin
               d = decisions_due.pop_front();
               if (rsp.cpu_choice !== d.cpu) begin
                  $error("cpu_choice expected %0d actual %0d", d.cpu, rsp.cpu_choice);
                  failures++;
               end
               if (rsp.io_choice !== d.io) begin
                  $error("io_choice expected %0d actual %0d", d.io, rsp.io_choice);
                  failures++;
               end
            end
         end
      end
      pending = decisions_due.size();
   end

   initial begin
      failures = 0;
      pending  = 0;
   end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives scheduler event words with random idling on both channels, walks
// several register settings, and reports the checker's verdict
// ----------------------------------------------------------------------------
module testbench;
   import dmts_pkg::*;

   // opcodes the block ignores
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   // decide can walk the table three times and shift the whole gap store
   localparam int SETTLE_CYCLES = 500;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  csr_write = 0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    failures, pending;

   dmts_req_if req_chan ();
   dmts_rsp_if rsp_chan ();

   // stimulus bookkeeping
   logic [15:0] last_cpu = '0;
   int          base_t;
   int          counted;
   int          arrive_pct;

   always #5 clock = ~clock;

   deadline_mlfq_task_scheduler u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   dmts_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .failures  (failures),
      .pending   (pending)
   );

   // remember the last cpu pick so decide can report it as still running,
   // which is what makes demotion happen
   always @(posedge clock) begin
      if (rsp_chan.valid && rsp_chan.ready) last_cpu <= rsp_chan.cpu_choice;
   end

   // receiver stalls: stretches of ready, short stalls, now and then a long one
   int rsp_hold = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end else if (rsp_chan.ready) begin
         rsp_chan.ready = 0;
         rsp_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(0, 3);
      end else begin
         rsp_chan.ready = 1;
         rsp_hold = $urandom_range(1, 40);
      end
   end

   // one event word; valid stays high when no gap follows
   task automatic send_word(logic [2:0] op, logic [30:0] et, logic [15:0] id,
                            logic [30:0] arr, logic [30:0] due, logic hi,
                            logic [15:0] rcpu, logic [15:0] rio);
      int gap;
      @(negedge clock);
      req_chan.valid         = 1;
      req_chan.opcode        = op;
      req_chan.event_time    = et;
      req_chan.task_ident    = id;
      req_chan.arrival_time  = arr;
      req_chan.due_time      = due;
      req_chan.high_priority = hi;
      req_chan.running_cpu   = rcpu;
      req_chan.running_io    = rio;
      do @(posedge clock); while (!req_chan.ready);
      if (op != OP_SPARE_A && op != OP_SPARE_B) counted++;
      gap = 0;
      if ($urandom_range(0, 1) == 0)
         gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid = 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_reg(csr_type idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write = 1;
      csr_index = idx;
      csr_data  = val;
      @(negedge clock);
      csr_write = 0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_chan.valid = 0;
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_ident();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return 16'($urandom_range(1, 40));
      if (r < 85) return '0;
      return 16'($urandom);
   endfunction

   function automatic logic [30:0] near_time(int spread);
      int v;
      v = base_t + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      return 31'(v);
   endfunction

   // usually a tick, then a handful of events, then decide
   task automatic run_episode();
      int          n, r;
      logic [15:0] rcpu, rio;
      logic [30:0] at;
      if ($urandom_range(0, 9) < 7) begin
         base_t = base_t + $urandom_range(0, 300);
         if ($urandom_range(0, 40) == 0) base_t = $urandom_range(0, 1000);
         if ($urandom_range(0, 30) == 0)
            send_word(OP_TICK, 31'($urandom), '0, '0, '0, 0, '0, '0);
         else
            send_word(OP_TICK, 31'(base_t), pick_ident(), 31'($urandom), 31'($urandom),
                      1'($urandom), 16'($urandom), 16'($urandom));
      end
      n = $urandom_range(1, 6);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < arrive_pct) begin
            if ($urandom_range(0, 15) == 0) begin
               send_word(OP_ARRIVE, 31'($urandom), pick_ident(), 31'($urandom),
                         31'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
            end else begin
               at = near_time(200);
               send_word(OP_ARRIVE, 31'($urandom), pick_ident(), at, near_time(800),
                         1'($urandom), 16'($urandom), 16'($urandom));
            end
         end else if (r < arrive_pct + 20) begin
            send_word(OP_TO_IO, 31'($urandom), pick_ident(), '0, '0, 0, '0, '0);
         end else if (r < arrive_pct + 35) begin
            send_word(OP_IO_DONE, 31'($urandom), pick_ident(), '0, '0, 0, '0, '0);
         end else if (r < 97) begin
            send_word(OP_FINISH, 31'($urandom), pick_ident(), '0, '0, 0, '0, '0);
         end else begin
            send_word($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, 31'($urandom),
                      16'($urandom), 31'($urandom), 31'($urandom), 1'($urandom),
                      16'($urandom), 16'($urandom));
         end
      end
      rcpu = ($urandom_range(0, 9) < 6) ? last_cpu : pick_ident();
      rio  = ($urandom_range(0, 9) < 7) ? 16'h0000 : pick_ident();
      send_word(OP_DECIDE, 31'($urandom), 16'($urandom), 31'($urandom), 31'($urandom),
                1'($urandom), rcpu, rio);
   endtask

   task automatic random_phase(int words, int arrive_weight);
      int stop_at;
      arrive_pct = arrive_weight;
      stop_at = counted + words;
      while (counted < stop_at) run_episode();
   endtask

   initial begin
      req_chan.valid         = 0;
      req_chan.opcode        = OP_TICK;
      req_chan.event_time    = '0;
      req_chan.task_ident    = '0;
      req_chan.arrival_time  = '0;
      req_chan.due_time      = '0;
      req_chan.high_priority = 0;
      req_chan.running_cpu   = '0;
      req_chan.running_io    = '0;
      base_t  = 100;
      counted = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty table, extremes, duplicates, unknown tasks, ignored codes
      send_word(OP_DECIDE, '0, '0, '0, '0, 0, 16'hFFFF, 16'h0000);
      send_word(OP_DECIDE, '0, '0, '0, '0, 0, 16'h0000, 16'hFFFF);
      send_word(OP_ARRIVE, '0, 16'hFFFF, '0, 31'h7FFFFFFF, 1, '0, '0);
      send_word(OP_ARRIVE, '0, 16'h0005, 31'h7FFFFFFF, '0, 0, '0, '0);
      send_word(OP_ARRIVE, '0, 16'h0005, 31'd50, 31'd900, 1, '0, '0);
      send_word(OP_ARRIVE, '0, 16'h0007, 31'd50, 31'd900, 0, '0, '0);
      send_word(OP_DECIDE, '0, '0, '0, '0, 0, 16'h0001, 16'h0000);
      send_word(OP_TICK, 31'd0, '0, '0, '0, 0, '0, '0);
      send_word(OP_TO_IO, '0, 16'h0005, '0, '0, 0, '0, '0);
      send_word(OP_TO_IO, '0, 16'h0777, '0, '0, 0, '0, '0);
      send_word(OP_DECIDE, '0, '0, '0, '0, 0, 16'hFFFF, 16'h0000);
      send_word(OP_TICK, 31'h7FFFFFFF, '0, '0, '0, 0, '0, '0);
      send_word(OP_DECIDE, '0, '0, '0, '0, 0, 16'hFFFF, 16'h0000);
      send_word(OP_TICK, 31'd1000, '0, '0, '0, 0, '0, '0);
      send_word(OP_DECIDE, '0, '0, '0, '0, 0, 16'hFFFF, 16'h0000);
      send_word(OP_IO_DONE, '0, 16'h0005, '0, '0, 0, '0, '0);
      send_word(OP_IO_DONE, '0, 16'h0123, '0, '0, 0, '0, '0);
      send_word(OP_FINISH, '0, 16'h0005, '0, '0, 0, '0, '0);
      send_word(OP_FINISH, '0, 16'h0999, '0, '0, 0, '0, '0);
      send_word(OP_SPARE_A, 31'h7FFFFFFF, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1,
                16'hFFFF, 16'hFFFF);
      send_word(OP_SPARE_B, '0, '0, '0, '0, 0, '0, '0);
      send_word(OP_DECIDE, '0, '0, '0, '0, 0, 16'h0007, 16'h0009);
      settle();

      // reset weights, arrival heavy so the table fills and drops arrivals
      random_phase(150, 60);
      settle();
      write_reg(CSR_WEIGHT_HIGH, 16'd0);
      write_reg(CSR_WEIGHT_LOW, 16'd0);
      write_reg(CSR_GAP_FRACTION, 16'd0);
      random_phase(130, 30);
      settle();
      write_reg(CSR_WEIGHT_HIGH, 16'd1023);
      write_reg(CSR_WEIGHT_LOW, 16'd1023);
      write_reg(CSR_GAP_FRACTION, 16'hFFFF);
      random_phase(130, 45);
      settle();
      write_reg(CSR_WEIGHT_HIGH, 16'($urandom_range(0, 1023)));
      write_reg(CSR_WEIGHT_LOW, 16'($urandom_range(0, 1023)));
      write_reg(CSR_GAP_FRACTION, 16'($urandom));
      random_phase(130, 20);
      settle();
      write_reg(CSR_WEIGHT_HIGH, 16'd1);
      write_reg(CSR_WEIGHT_LOW, 16'd1023);
      write_reg(CSR_GAP_FRACTION, 16'h8000);
      random_phase(130, 50);

      settle();
      if (failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #60ms;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
